/* design/fiq_pkg.sv */
// ----------------------------------------------------------------------------
// fiq_pkg - shared types and constants for the frame interval quantizer
// Fixed field widths and the sequencer state type.
// ----------------------------------------------------------------------------
package fiq_pkg;

	localparam int TS_BITS     = 64;
	localparam int PERIOD_BITS = 20;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIFF,
		ST_DEBT,
		ST_COMP,
		ST_DIV,
		ST_FIX,
		ST_OUT
	} fiq_state_t;

endpackage

/* design/frame_interval_quantizer.sv */
// ----------------------------------------------------------------------------
// frame_interval_quantizer - frame interval measurement and period quantizer
// Turns frame-mark timestamps into raw and display-period quantized intervals.
// ----------------------------------------------------------------------------
// Usage:
//   Input items (in_valid/in_ready) carry a 64-bit microsecond timestamp.
//   Result items (out_valid/out_ready) carry frame_dt_us and raw_dt_us.
//   The display period is written through cfg_we/cfg_wdata while idle.
//   The first mark after reset is only stored and gives no result.
//   Every later mark gives one result. With period zero an item passes
//   through the difference and output states; with a period and no debt
//   correction it also passes the debt and compare states; when surplus
//   debt has to be folded into whole periods, a restoring subtract/compare
//   unit steps through the widened debt one bit a cycle. in_ready is high
//   only between items.
//   The result lands in an output register: the block takes the next item
//   while it waits, and holds the following result until the register is
//   free when the receiver stalls.
//   Reset clears the period, the debt and the stored mark.
// ----------------------------------------------------------------------------
module frame_interval_quantizer
	import fiq_pkg::*;
#(
	parameter int DT_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [TS_BITS-1:0]     timestamp_us,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [DT_BITS-1:0]     frame_dt_us,
	output logic [DT_BITS-1:0]     raw_dt_us,
	input  logic                   cfg_we,
	input  logic [PERIOD_BITS-1:0] cfg_wdata
);

	localparam int DBW = ((DT_BITS > 21) ? DT_BITS : 21) + 3;
	localparam int NW  = DBW + 1;
	localparam int CW  = $clog2(NW);
	localparam int RW  = PERIOD_BITS + 2;
	localparam logic [DT_BITS-1:0] DT_MAX = '1;

	fiq_state_t state_q, state_d;

	logic [TS_BITS-1:0]     ts_q;
	logic [TS_BITS-1:0]     prev_q;
	logic                   have_q;
	logic signed [DBW-1:0]  debt_q;
	logic [PERIOD_BITS-1:0] period_q;
	logic [PERIOD_BITS-1:0] p_q;
	logic [DT_BITS-1:0]     raw_q;
	logic [DT_BITS-1:0]     frame_q;
	logic [NW-1:0]          num_q;
	logic [RW-1:0]          rem_q;
	logic [CW-1:0]          cnt_q;
	logic                   out_valid_q;
	logic [DT_BITS-1:0]     frame_out_q;
	logic [DT_BITS-1:0]     raw_out_q;

	logic [TS_BITS-1:0]     diff;
	logic [DT_BITS-1:0]     raw_sat;
	logic signed [DBW-1:0]  p_dbw;
	logic signed [DBW-1:0]  raw_dbw;
	logic signed [DBW-1:0]  debt_add;
	logic signed [DBW-1:0]  debt_up;
	logic signed [NW-1:0]   twod;
	logic signed [NW-1:0]   p_nw;
	logic signed [NW-1:0]   p3_nw;
	logic                   over;
	logic                   under;
	logic [NW-1:0]          num_init;
	logic [RW-1:0]          twop;
	logic [RW-1:0]          rem_sh;
	logic [RW-1:0]          rem_nx;
	logic [RW:0]            half_sum;
	logic signed [DBW-1:0]  debt_new;
	logic signed [DBW:0]    fix_v;
	logic [DT_BITS-1:0]     fix_sat;
	logic                   accept;
	logic                   out_free;

	// ---------------- datapath ----------------
	assign diff    = ts_q - prev_q;
	assign raw_sat = (|diff[TS_BITS-1:DT_BITS]) ? DT_MAX : diff[DT_BITS-1:0];

	assign p_dbw    = $signed(DBW'(p_q));
	assign raw_dbw  = $signed(DBW'(raw_q));
	assign debt_add = debt_q + raw_dbw - p_dbw;
	assign debt_up  = debt_q + p_dbw;

	// thresholds 1.5P and -0.5P compared on doubled debt
	assign twod     = $signed({debt_q, 1'b0});
	assign p_nw     = $signed(NW'(p_q));
	assign p3_nw    = p_nw + $signed({p_nw[NW-2:0], 1'b0});
	assign over     = twod > p3_nw;
	assign under    = twod < -p_nw;
	assign num_init = NW'(twod - p_nw - $signed(NW'(1)));

	// restoring step: remainder of num by 2P
	assign twop   = {1'b0, p_q, 1'b0};
	assign rem_sh = {rem_q[RW-2:0], num_q[NW-1]};
	assign rem_nx = (rem_sh >= twop) ? (rem_sh - twop) : rem_sh;

	// debt left after removing k periods is (rem + P + 1) / 2
	assign half_sum = (RW+1)'(rem_q) + (RW+1)'(p_q) + (RW+1)'(1);
	assign debt_new = $signed(DBW'(half_sum[RW:1]));
	// k*P + P, from the debt drop
	assign fix_v    = $signed({debt_q[DBW-1], debt_q}) + $signed((DBW+1)'(p_q))
	                - $signed({debt_new[DBW-1], debt_new});
	assign fix_sat  = (|fix_v[DBW:DT_BITS]) ? DT_MAX : fix_v[DT_BITS-1:0];

	// ---------------- sequencer ----------------
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && have_q) begin
					state_d = ST_DIFF;
				end
			end
			ST_DIFF: begin
				state_d = (period_q == '0) ? ST_OUT : ST_DEBT;
			end
			ST_DEBT: begin
				state_d = ST_COMP;
			end
			ST_COMP: begin
				state_d = over ? ST_DIV : ST_OUT;
			end
			ST_DIV: begin
				if (cnt_q == '0) begin
					state_d = ST_FIX;
				end
			end
			ST_FIX: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control and state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= '0;
			have_q      <= 1'b0;
			debt_q      <= '0;
			period_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				period_q <= cfg_wdata;
			end
			if (accept && !have_q) begin
				prev_q <= timestamp_us;
				have_q <= 1'b1;
			end
			if (state_q == ST_DIFF) begin
				prev_q <= ts_q;
			end
			if (state_q == ST_DEBT) begin
				debt_q <= debt_add;
			end
			if (state_q == ST_COMP && !over && under) begin
				debt_q <= debt_up;
			end
			if (state_q == ST_FIX) begin
				debt_q <= debt_new;
			end
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload and working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			ts_q <= timestamp_us;
		end
		unique case (state_q)
			ST_DIFF: begin
				raw_q   <= raw_sat;
				frame_q <= raw_sat;
				p_q     <= period_q;
			end
			ST_COMP: begin
				if (over) begin
					num_q <= num_init;
					rem_q <= '0;
					cnt_q <= CW'(NW - 1);
				end else if (under) begin
					frame_q <= '0;
				end else begin
					frame_q <= DT_BITS'(p_q);
				end
			end
			ST_DIV: begin
				rem_q <= rem_nx;
				num_q <= {num_q[NW-2:0], 1'b0};
				cnt_q <= cnt_q - CW'(1);
			end
			ST_FIX: begin
				frame_q <= fix_sat;
			end
			ST_OUT: begin
				if (out_free) begin
					frame_out_q <= frame_q;
					raw_out_q   <= raw_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid   = out_valid_q;
	assign frame_dt_us = frame_out_q;
	assign raw_dt_us   = raw_out_q;

	// ---------------- assertions ----------------
	a_first_mark: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !have_q) |=> (have_q && state_q == ST_IDLE))
		else $error("first mark did not just store the time");

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < twop))
		else $error("division remainder out of range");

	a_pass_through: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIFF && period_q == '0) |=> (frame_q == raw_q && state_q == ST_OUT))
		else $error("zero period did not pass the raw interval");

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && out_free) |=> (out_valid && state_q == ST_IDLE))
		else $error("result not loaded into output register");

endmodule
